FILE: sv/merged_interval_set_core_macros.svh
// assertion helpers for the interval set core
`ifndef MERGED_INTERVAL_SET_CORE_MACROS_SVH
`define MERGED_INTERVAL_SET_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define MIS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("interval set check failed");

// next-cycle implication, quiet during reset
`define MIS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("interval set check failed");

`endif

FILE: sv/mis_pkg.sv
package mis_pkg;

  // operation codes
  localparam logic [2:0] MODE_QUERY     = 3'd0;
  localparam logic [2:0] MODE_ADD_VALUE = 3'd1;
  localparam logic [2:0] MODE_ADD_RANGE = 3'd2;
  localparam logic [2:0] MODE_REMOVE    = 3'd3;
  localparam logic [2:0] MODE_POP       = 3'd4;
  localparam logic [2:0] MODE_PRUNE     = 3'd5;
  localparam logic [2:0] MODE_CLEAR     = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] value;
    logic [31:0] value_high;
  } cmd_t;

  typedef struct packed {
    logic        was_member;
    logic [31:0] popped_value;
    logic [1:0]  status;
    logic [6:0]  range_count;
    logic [32:0] member_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
  } span_t;

  // range held back for merging or emitted one step late
  typedef struct packed {
    logic  valid;
    span_t s;
  } pend_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] value;
    logic        first;
  } step_ctl_t;

  typedef struct packed {
    logic  wr_en;
    span_t wr;
    logic  hit;
  } step_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_DONE
  } state_t;

  function automatic logic [32:0] span_size(span_t s);
    return {1'b0, s.hi} - {1'b0, s.lo} + 33'd1;
  endfunction

endpackage

FILE: sv/merged_interval_set_core.sv
// channel | word  | accepted when
// cmd     | cmd_t | cmd_valid && !cmd_stall
// rsp     | rsp_t | rsp_valid && !rsp_stall
//
// each command runs through the accept cycle, one memory read per stored
// range, draining the read, a flush step and a result step
// the table is rebuilt from one memory half into the other; the halves swap
// on success, so a full-table failure leaves the old half in place
// reset empties the set at once, no clearing pass
// a stalled response holds the core in its result step
module merged_interval_set_core #(
  parameter int MAX_RANGES = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  mis_pkg::cmd_t  cmd,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  output mis_pkg::rsp_t  rsp,
  output logic           rsp_valid,
  input  logic           rsp_stall
);
  import mis_pkg::*;

  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW = $clog2(MAX_RANGES + 2);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

  state_t      state, state_next;
  logic        bank;
  logic [CW-1:0] used, rc, wc;
  logic [32:0] total, sum;
  logic        dv, first, member;
  pend_t       p, p_step;
  cmd_t        item;
  logic [31:0] popped;
  span_t       rdata, wr_span;
  step_ctl_t   ctl;
  step_res_t   res;
  logic        accept, issue, flush_wr, wr_any, ram_we, full, done_go;
  logic [1:0]  status;

  mis_ram #(.W(64), .AW(AW + 1)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr({~bank, wc[AW-1:0]}),
    .wdata(wr_span),
    .raddr({bank, rc[AW-1:0]}),
    .rdata(rdata)
  );

  assign ctl = '{mode: item.mode, value: item.value, first: first};

  mis_step u_step (
    .p     (p),
    .e     (rdata),
    .ctl   (ctl),
    .p_next(p_step),
    .res   (res)
  );

  // handshake and write control
  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign issue     = (state == S_SCAN) && (rc < used);
  assign flush_wr  = (state == S_FLUSH) && p.valid;
  assign wr_any    = (dv && res.wr_en) || flush_wr;
  assign wr_span   = flush_wr ? p.s : res.wr;
  assign ram_we    = wr_any && (wc < MAX_CNT);
  assign full      = (wc > MAX_CNT);
  assign done_go   = (state == S_DONE) && (!rsp_valid || !rsp_stall);

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_SCAN;
      S_SCAN:  if (!issue && !dv) state_next = S_FLUSH;
      S_FLUSH: state_next = S_DONE;
      S_DONE:  if (done_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // result status
  always_comb begin
    status = ST_OK;
    if (full) begin
      status = ST_FULL;
    end else begin
      case (item.mode) inside
        MODE_QUERY, MODE_REMOVE: status = member ? ST_OK : ST_MISS;
        MODE_POP:                status = (used == '0) ? ST_MISS : ST_OK;
        default:                 status = ST_OK;
      endcase
    end
  end

  // control state and commit
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bank      <= 1'b0;
      used      <= '0;
      total     <= '0;
      dv        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      dv    <= issue;
      if (done_go) begin
        rsp_valid <= 1'b1;
        if (!full) begin
          bank  <= ~bank;
          used  <= wc;
          total <= sum;
        end
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // rebuild datapath and response word
  always_ff @(posedge clk) begin
    if (accept) begin
      item    <= cmd;
      rc      <= '0;
      wc      <= '0;
      sum     <= '0;
      member  <= 1'b0;
      first   <= 1'b1;
      popped  <= '0;
      p.valid <= (cmd.mode == MODE_ADD_VALUE) ||
                 ((cmd.mode == MODE_ADD_RANGE) && (cmd.value_high >= cmd.value));
      p.s.lo  <= cmd.value;
      p.s.hi  <= (cmd.mode == MODE_ADD_VALUE) ? cmd.value : cmd.value_high;
    end
    if (issue) begin
      rc <= rc + 1'b1;
    end
    if (dv) begin
      p      <= p_step;
      member <= member | res.hit;
      first  <= 1'b0;
      if (first && (item.mode == MODE_POP)) begin
        popped <= rdata.lo;
      end
    end
    if (wr_any) begin
      wc  <= wc + 1'b1;
      sum <= sum + span_size(wr_span);
    end
    if (done_go) begin
      rsp.was_member   <= member;
      rsp.popped_value <= full ? 32'd0 : popped;
      rsp.status       <= status;
      rsp.range_count  <= full ? 7'(used) : 7'(wc);
      rsp.member_count <= full ? total : sum;
    end
  end

`include "merged_interval_set_core_macros.svh"

  `MIS_ASSERT_NEXT(a_start_scan, cmd_valid && !cmd_stall, state == S_SCAN)
  `MIS_ASSERT_NOW(a_used_bound, 1'b1, used <= MAX_CNT)
  `MIS_ASSERT_NOW(a_read_in_scan, dv, state == S_SCAN)

endmodule

FILE: sv/mis_ram.sv
module mis_ram #(
  parameter int W  = 64,
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [2**AW];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/mis_step.sv
module mis_step (
  input  mis_pkg::pend_t     p,
  input  mis_pkg::span_t     e,
  input  mis_pkg::step_ctl_t ctl,
  output mis_pkg::pend_t     p_next,
  output mis_pkg::step_res_t res
);
  import mis_pkg::*;

  logic        na;
  logic        nb;
  logic        hit;
  span_t       a;
  span_t       b;
  logic        merge;
  logic        below;
  logic [32:0] a_hi1;
  logic [32:0] p_hi1;

  // split the old range into the pieces this operation keeps
  always_comb begin
    hit = (e.lo <= ctl.value) && (ctl.value <= e.hi);
    na = 1'b1;
    nb = 1'b0;
    a  = e;
    b  = e;
    case (ctl.mode)
      MODE_REMOVE: begin
        if (hit) begin
          if (e.lo == e.hi) begin
            na = 1'b0;
          end else if (e.lo == ctl.value) begin
            a.lo = ctl.value + 32'd1;
          end else if (e.hi == ctl.value) begin
            a.hi = ctl.value - 32'd1;
          end else begin
            a.hi = ctl.value - 32'd1;
            nb   = 1'b1;
            b.lo = ctl.value + 32'd1;
          end
        end
      end
      MODE_POP: begin
        if (ctl.first) begin
          if (e.lo == e.hi) begin
            na = 1'b0;
          end else begin
            a.lo = e.lo + 32'd1;
          end
        end
      end
      MODE_PRUNE: begin
        na = (e.hi >= ctl.value);
      end
      MODE_CLEAR: begin
        na = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // merge the piece with the held range or emit in order
  always_comb begin
    a_hi1 = {1'b0, a.hi} + 33'd1;
    p_hi1 = {1'b0, p.s.hi} + 33'd1;
    merge = (a_hi1 >= {1'b0, p.s.lo}) && (p_hi1 >= {1'b0, a.lo});
    below = (a_hi1 < {1'b0, p.s.lo});
    p_next    = p;
    res.hit   = hit;
    res.wr_en = 1'b0;
    res.wr    = a;
    if (na) begin
      if (!p.valid) begin
        res.wr_en = 1'b1;
      end else if (merge) begin
        p_next.s.lo = (a.lo < p.s.lo) ? a.lo : p.s.lo;
        p_next.s.hi = (a.hi > p.s.hi) ? a.hi : p.s.hi;
      end else if (below) begin
        res.wr_en = 1'b1;
      end else begin
        res.wr_en = 1'b1;
        res.wr    = p.s;
        p_next.s  = a;
      end
    end
    if (nb) begin
      p_next.valid = 1'b1;
      p_next.s     = b;
    end
  end

endmodule
